@@ rtl/hbbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc_pkg
// Shared widths, codes and item types of the hashed block buffer cache.
// ----------------------------------------------------------------------------
package hbbc_pkg;

  localparam int REQ_W    = 2;
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int HANDLE_W = 6;
  localparam int STAT_W   = 2;
  localparam int REFS_W   = 8;
  localparam int BKT_W    = 4;

  localparam int NUM_BUFFERS_DEF = 30;
  localparam int NUM_BUCKETS_DEF = 13;

  // request codes
  localparam logic [REQ_W-1:0] REQ_GET     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PIN     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNPIN   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [DEV_W-1:0]    device_id;
    logic [BLK_W-1:0]    block_number;
    logic [HANDLE_W-1:0] buffer_handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] granted_buffer;
    logic                needs_fill;
    logic                was_cached;
    logic [STAT_W-1:0]   status;
  } rsp_t;

endpackage

@@ rtl/hbbc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc request / response channels
// Valid-ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hbbc_req_if;
  logic            valid;
  logic            ready;
  hbbc_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hbbc_rsp_if;
  logic            valid;
  logic            ready;
  hbbc_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/hashed_block_buffer_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// Buffer pool kept in per-bucket recency lists, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one request item (get / release / pin / unpin) per handshake.
//   out_rsp : exactly one response item per request, in request order.
// The block takes one request at a time; in_req.ready is high only while the
// sequencer is idle. A result waiting in the output register does not block
// the next request; only a second result waits until out_rsp.ready.
// Sequence: a get first runs the block mod bucket step (one 4-bit digit a
// cycle through a constant remainder table), then walks one list node per
// cycle through the link memories, the closing head included, over match and
// free scans of up to NUM_BUCKETS buckets; a buffer that moves bucket then
// passes the unlink, head read and push steps before the result is posted.
// Release, pin and unpin read the handle's count and update it, and a release
// that frees the buffer moves it to its bucket head. An out-of-range handle
// goes straight to posting the result.
// Reset: after rst_n the block runs a clearing pass over all buffers and then
// all bucket heads that rebuilds the lists; in_req.ready stays low then.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache #(
  parameter int NUM_BUFFERS = hbbc_pkg::NUM_BUFFERS_DEF,
  parameter int NUM_BUCKETS = hbbc_pkg::NUM_BUCKETS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hbbc_req_if.sink   in_req,
  hbbc_rsp_if.source out_rsp
);
  import hbbc_pkg::*;

  localparam int NODES     = NUM_BUFFERS + NUM_BUCKETS;
  localparam int NW        = $clog2(NODES);
  localparam int BW        = $clog2(NUM_BUFFERS);
  localparam int INIT_R    = (NUM_BUFFERS - 1) % NUM_BUCKETS;
  localparam int INIT_BASE = NUM_BUFFERS - 1 - INIT_R;
  localparam int NIBS      = BLK_W / 4;
  localparam int MOD_N     = 1 << (BKT_W + 4);

  localparam logic [NW-1:0]    NB_N   = NW'(NUM_BUFFERS);
  localparam logic [NW-1:0]    NK_N   = NW'(NUM_BUCKETS);
  localparam logic [BKT_W-1:0] K_LAST = BKT_W'(NUM_BUCKETS - 1);

  // remainder table: entry {r, d} holds (16 * r + d) mod bucket count
  function automatic logic [MOD_N*BKT_W-1:0] mod_table();
    logic [MOD_N*BKT_W-1:0] t;
    t = '0;
    for (int i = 0; i < MOD_N; i++) t[i*BKT_W +: BKT_W] = BKT_W'(i % NUM_BUCKETS);
    return t;
  endfunction

  localparam logic [MOD_N*BKT_W-1:0] MOD_TAB = mod_table();

  // sequencer states
  localparam logic [3:0] S_INIT_BUF  = 4'd0;
  localparam logic [3:0] S_INIT_HEAD = 4'd1;
  localparam logic [3:0] S_IDLE      = 4'd2;
  localparam logic [3:0] S_MOD       = 4'd3;
  localparam logic [3:0] S_SCAN_HEAD = 4'd4;
  localparam logic [3:0] S_SCAN_FRST = 4'd5;
  localparam logic [3:0] S_WALK      = 4'd6;
  localparam logic [3:0] S_OP_RD     = 4'd7;
  localparam logic [3:0] S_OP_EXEC   = 4'd8;
  localparam logic [3:0] S_MV_UNLINK = 4'd9;
  localparam logic [3:0] S_MV_RDH    = 4'd10;
  localparam logic [3:0] S_MV_PUSH1  = 4'd11;
  localparam logic [3:0] S_MV_PUSH2  = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  // memories
  logic [NW-1:0]     fwd_mem [NODES];
  logic [NW-1:0]     bwd_mem [NODES];
  logic [DEV_W-1:0]  dev_mem [NUM_BUFFERS];
  logic [BLK_W-1:0]  blk_mem [NUM_BUFFERS];
  logic              val_mem [NUM_BUFFERS];
  logic [REFS_W-1:0] refs_mem[NUM_BUFFERS];
  logic [BKT_W-1:0]  bkt_mem [NUM_BUFFERS];

  // read port (registered data) and write ports
  logic [NW-1:0]     ra;
  logic [NW-1:0]     rd_fwd, rd_bwd;
  logic [DEV_W-1:0]  rd_dev;
  logic [BLK_W-1:0]  rd_blk;
  logic              rd_val;
  logic [REFS_W-1:0] rd_refs;
  logic [BKT_W-1:0]  rd_bkt;

  logic              fwd_we, bwd_we;
  logic [NW-1:0]     fwd_wa, fwd_wd, bwd_wa, bwd_wd;
  logic              id_we, val_we, refs_we, bkt_we;
  logic [NW-1:0]     ent_wa;
  logic [DEV_W-1:0]  dev_wd;
  logic [BLK_W-1:0]  blk_wd;
  logic              val_wd;
  logic [REFS_W-1:0] refs_wd;
  logic [BKT_W-1:0]  bkt_wd;

  // control and payload registers
  logic [3:0]        state_r, state_nxt;
  logic [NW-1:0]     cur_r, cur_nxt;
  logic [NW-1:0]     init_i_r, init_i_nxt;
  logic [BKT_W-1:0]  init_k_r, init_k_nxt;
  logic [BKT_W-1:0]  k_r, k_nxt;
  logic [BKT_W-1:0]  j_r, j_nxt;
  logic [BKT_W-1:0]  home_r, home_nxt;
  logic              free_r, free_nxt;
  logic [2:0]        mod_cnt_r, mod_cnt_nxt;
  logic [BKT_W-1:0]  rem_r, rem_nxt;
  req_t              req_r, req_nxt;
  logic [NW-1:0]     mv_node_r, mv_node_nxt;
  logic [NW-1:0]     mv_f_r, mv_f_nxt;
  logic [NW-1:0]     mv_b_r, mv_b_nxt;
  logic [BKT_W-1:0]  mv_bkt_r, mv_bkt_nxt;
  logic [NW-1:0]     first_r, first_nxt;
  rsp_t              res_r, res_nxt;
  rsp_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // link memories
  always_ff @(posedge clk) begin
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
    rd_fwd <= fwd_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
    rd_bwd <= bwd_mem[ra];
  end

  // buffer entry memories, read at the same node address
  always_ff @(posedge clk) begin
    if (id_we) begin
      dev_mem[BW'(ent_wa)] <= dev_wd;
      blk_mem[BW'(ent_wa)] <= blk_wd;
    end
    rd_dev <= dev_mem[BW'(ra)];
    rd_blk <= blk_mem[BW'(ra)];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[BW'(ent_wa)] <= val_wd;
    rd_val <= val_mem[BW'(ra)];
  end

  always_ff @(posedge clk) begin
    if (refs_we) refs_mem[BW'(ent_wa)] <= refs_wd;
    rd_refs <= refs_mem[BW'(ra)];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[BW'(ent_wa)] <= bkt_wd;
    rd_bkt <= bkt_mem[BW'(ra)];
  end

  // shared compare / step logic
  logic [NW-1:0]     head_n, next_n, mv_head_n;
  logic [NW:0]       init_up, init_last;
  logic [3:0]        blk_nib;
  logic [BKT_W+3:0]  mod_idx;
  logic              cur_is_buf, match_hit, free_hit;
  logic [REFS_W-1:0] refs_inc;

  assign head_n     = NB_N + NW'(k_r);
  assign mv_head_n  = NB_N + NW'(mv_bkt_r);
  assign next_n     = free_r ? rd_bwd : rd_fwd;
  assign cur_is_buf = (cur_r < NB_N);
  assign match_hit  = !free_r && cur_is_buf && (rd_dev == req_r.device_id)
                      && (rd_blk == req_r.block_number);
  assign free_hit   = free_r && cur_is_buf && (rd_refs == '0);
  assign refs_inc   = (rd_refs == '1) ? rd_refs : rd_refs + 1'b1;
  assign init_up    = {1'b0, init_i_r} + {1'b0, NK_N};
  assign init_last  = (NW+1)'(INIT_BASE) + (NW+1)'(init_k_r)
                      - ((init_k_r > BKT_W'(INIT_R)) ? (NW+1)'(NUM_BUCKETS) : '0);
  assign blk_nib    = req_r.block_number[4*(NIBS-1-int'(mod_cnt_r)) +: 4];
  assign mod_idx    = {rem_r, blk_nib};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    init_i_nxt    = init_i_r;
    init_k_nxt    = init_k_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    home_nxt      = home_r;
    free_nxt      = free_r;
    mod_cnt_nxt   = mod_cnt_r;
    rem_nxt       = rem_r;
    req_nxt       = req_r;
    mv_node_nxt   = mv_node_r;
    mv_f_nxt      = mv_f_r;
    mv_b_nxt      = mv_b_r;
    mv_bkt_nxt    = mv_bkt_r;
    first_nxt     = first_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ra            = cur_r;
    fwd_we        = 1'b0;
    bwd_we        = 1'b0;
    fwd_wa        = '0;
    fwd_wd        = '0;
    bwd_wa        = '0;
    bwd_wd        = '0;
    id_we         = 1'b0;
    val_we        = 1'b0;
    refs_we       = 1'b0;
    bkt_we        = 1'b0;
    ent_wa        = cur_r;
    dev_wd        = req_r.device_id;
    blk_wd        = req_r.block_number;
    val_wd        = 1'b1;
    refs_wd       = '0;
    bkt_wd        = '0;

    if (out_valid_r && out_rsp.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      // clearing pass over buffers: rebuild the insertion-order lists
      S_INIT_BUF: begin
        fwd_we  = 1'b1;
        bwd_we  = 1'b1;
        fwd_wa  = init_i_r;
        bwd_wa  = init_i_r;
        fwd_wd  = (init_i_r >= NK_N) ? init_i_r - NK_N : NB_N + NW'(init_k_r);
        bwd_wd  = (init_up < (NW+1)'(NUM_BUFFERS)) ? NW'(init_up)
                                                   : NB_N + NW'(init_k_r);
        ent_wa  = init_i_r;
        id_we   = 1'b1;
        dev_wd  = '0;
        blk_wd  = '0;
        val_we  = 1'b1;
        val_wd  = 1'b0;
        refs_we = 1'b1;
        bkt_we  = 1'b1;
        bkt_wd  = init_k_r;
        init_k_nxt = (init_k_r == K_LAST) ? '0 : init_k_r + 1'b1;
        init_i_nxt = init_i_r + 1'b1;
        if (init_i_r == NB_N - 1'b1) begin
          init_k_nxt = '0;
          state_nxt  = S_INIT_HEAD;
        end
      end

      // clearing pass over bucket heads
      S_INIT_HEAD: begin
        fwd_we = 1'b1;
        bwd_we = 1'b1;
        fwd_wa = NB_N + NW'(init_k_r);
        bwd_wa = NB_N + NW'(init_k_r);
        if (NW'(init_k_r) < NB_N) begin
          fwd_wd = NW'(init_last);
          bwd_wd = NW'(init_k_r);
        end else begin
          fwd_wd = NB_N + NW'(init_k_r);
          bwd_wd = NB_N + NW'(init_k_r);
        end
        init_k_nxt = init_k_r + 1'b1;
        if (init_k_r == K_LAST) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_req.valid) begin
          req_nxt = in_req.data;
          res_nxt.granted_buffer = in_req.data.buffer_handle;
          res_nxt.needs_fill     = 1'b0;
          res_nxt.was_cached     = 1'b0;
          res_nxt.status         = ST_OK;
          if (in_req.data.req_type == REQ_GET) begin
            res_nxt.granted_buffer = '0;
            mod_cnt_nxt = '0;
            rem_nxt     = '0;
            state_nxt   = S_MOD;
          end else if ({1'b0, in_req.data.buffer_handle}
                       >= (HANDLE_W+1)'(NUM_BUFFERS)) begin
            state_nxt = S_DONE;
          end else begin
            cur_nxt   = NW'(in_req.data.buffer_handle);
            state_nxt = S_OP_RD;
          end
        end
      end

      // home bucket: block number mod bucket count, one nibble a cycle
      S_MOD: begin
        rem_nxt     = MOD_TAB[BKT_W*int'(mod_idx) +: BKT_W];
        mod_cnt_nxt = mod_cnt_r + 1'b1;
        if (mod_cnt_r == 3'(NIBS - 1)) begin
          home_nxt  = rem_nxt;
          k_nxt     = rem_nxt;
          j_nxt     = '0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN_HEAD;
        end
      end

      S_SCAN_HEAD: begin
        ra        = head_n;
        cur_nxt   = head_n;
        state_nxt = S_SCAN_FRST;
      end

      S_SCAN_FRST: begin
        ra        = next_n;
        cur_nxt   = next_n;
        state_nxt = S_WALK;
      end

      // one list node per cycle
      S_WALK: begin
        if (cur_r == head_n) begin
          if (!free_r) begin
            free_nxt  = 1'b1;
            state_nxt = S_SCAN_HEAD;
          end else if (j_r == K_LAST) begin
            res_nxt.status = ST_NO_FREE;
            state_nxt      = S_DONE;
          end else begin
            free_nxt  = 1'b0;
            j_nxt     = j_r + 1'b1;
            k_nxt     = (k_r == K_LAST) ? '0 : k_r + 1'b1;
            state_nxt = S_SCAN_HEAD;
          end
        end else if (match_hit || free_hit) begin
          ent_wa  = cur_r;
          val_we  = 1'b1;
          refs_we = 1'b1;
          refs_wd = match_hit ? refs_inc : REFS_W'(1);
          id_we   = free_hit;
          bkt_we  = (j_r != '0);
          bkt_wd  = home_r;
          res_nxt.granted_buffer = HANDLE_W'(cur_r);
          res_nxt.needs_fill     = match_hit ? !rd_val : 1'b1;
          res_nxt.was_cached     = match_hit;
          mv_node_nxt = cur_r;
          mv_f_nxt    = rd_fwd;
          mv_b_nxt    = rd_bwd;
          mv_bkt_nxt  = home_r;
          state_nxt   = (j_r != '0) ? S_MV_UNLINK : S_DONE;
        end else begin
          ra      = next_n;
          cur_nxt = next_n;
        end
      end

      S_OP_RD: begin
        state_nxt = S_OP_EXEC;
      end

      // release / pin / unpin on the count read for the handle
      S_OP_EXEC: begin
        ent_wa = cur_r;
        if (req_r.req_type == REQ_PIN) begin
          refs_we   = 1'b1;
          refs_wd   = refs_inc;
          state_nxt = S_DONE;
        end else if (rd_refs == '0) begin
          res_nxt.status = ST_UNDERFLOW;
          state_nxt      = S_DONE;
        end else begin
          refs_we   = 1'b1;
          refs_wd   = rd_refs - 1'b1;
          state_nxt = S_DONE;
          if (req_r.req_type == REQ_RELEASE && rd_refs == REFS_W'(1)) begin
            mv_node_nxt = cur_r;
            mv_f_nxt    = rd_fwd;
            mv_b_nxt    = rd_bwd;
            mv_bkt_nxt  = rd_bkt;
            state_nxt   = S_MV_UNLINK;
          end
        end
      end

      // move: unlink, read the bucket's first node, push at head
      S_MV_UNLINK: begin
        fwd_we    = 1'b1;
        fwd_wa    = mv_b_r;
        fwd_wd    = mv_f_r;
        bwd_we    = 1'b1;
        bwd_wa    = mv_f_r;
        bwd_wd    = mv_b_r;
        state_nxt = S_MV_RDH;
      end

      S_MV_RDH: begin
        ra        = mv_head_n;
        state_nxt = S_MV_PUSH1;
      end

      S_MV_PUSH1: begin
        first_nxt = rd_fwd;
        fwd_we    = 1'b1;
        fwd_wa    = mv_node_r;
        fwd_wd    = rd_fwd;
        bwd_we    = 1'b1;
        bwd_wa    = mv_node_r;
        bwd_wd    = mv_head_n;
        state_nxt = S_MV_PUSH2;
      end

      S_MV_PUSH2: begin
        bwd_we    = 1'b1;
        bwd_wa    = first_r;
        bwd_wd    = mv_node_r;
        fwd_we    = 1'b1;
        fwd_wa    = mv_head_n;
        fwd_wd    = mv_node_r;
        state_nxt = S_DONE;
      end

      // post the result once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT_BUF;
      init_i_r    <= '0;
      init_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_i_r    <= init_i_nxt;
      init_k_r    <= init_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    k_r       <= k_nxt;
    j_r       <= j_nxt;
    home_r    <= home_nxt;
    free_r    <= free_nxt;
    mod_cnt_r <= mod_cnt_nxt;
    rem_r     <= rem_nxt;
    req_r     <= req_nxt;
    mv_node_r <= mv_node_nxt;
    mv_f_r    <= mv_f_nxt;
    mv_b_r    <= mv_b_nxt;
    mv_bkt_r  <= mv_bkt_nxt;
    first_r   <= first_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_r;

endmodule

@@ rtl/hbbc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc_checker
// Port-level checks of the buffer cache, bound to the top level.
// ----------------------------------------------------------------------------
module hbbc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hbbc_pkg::HANDLE_W-1:0] granted_buffer,
  input logic                          needs_fill,
  input logic                          was_cached,
  input logic [hbbc_pkg::STAT_W-1:0]   status
);
  import hbbc_pkg::*;

  // a response holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(granted_buffer))
    else $error("response dropped or changed while stalled");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_NO_FREE
      || status == ST_UNDERFLOW))
    else $error("undefined status code");

  // a failed request reports no hit and no fill
  a_fail_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> !needs_fill && !was_cached)
    else $error("flags set on failed request");

endmodule

bind hashed_block_buffer_cache hbbc_checker u_hbbc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .granted_buffer (out_rsp.data.granted_buffer),
  .needs_fill     (out_rsp.data.needs_fill),
  .was_cached     (out_rsp.data.was_cached),
  .status         (out_rsp.data.status)
);

@@ tb/tb_hashed_block_buffer_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_block_buffer_cache
// Drives get / release / pin / unpin requests through the valid-ready request
// channel, predicts each response with a behavioral model of the bucket lists
// and compares every response field in order. Sender and receiver idle in
// several phases, including a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_hashed_block_buffer_cache;
  import hbbc_pkg::*;

  localparam int NBUF  = NUM_BUFFERS_DEF;
  localparam int NBKT  = NUM_BUCKETS_DEF;
  localparam int NNODE = NBUF + NBKT;
  localparam int NRAND = 1400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hbbc_req_if in_req ();
  hbbc_rsp_if out_rsp ();

  hashed_block_buffer_cache dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_rsp (out_rsp.source)
  );

  always #10 clk = ~clk;

  // cache image kept by the predictor
  logic [DEV_W-1:0]  c_dev  [NBUF];
  logic [BLK_W-1:0]  c_blk  [NBUF];
  logic              c_val  [NBUF];
  logic [REFS_W-1:0] c_refs [NBUF];
  int                c_bkt  [NBUF];
  int                nxt    [NNODE];
  int                prv    [NNODE];

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_cycles = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  bit   drain_now = 0;
  bit   in_taken = 0;

  // recently used blocks, to get hits
  logic [DEV_W-1:0] seen_dev [$];
  logic [BLK_W-1:0] seen_blk [$];

  function automatic void unlink(int n);
    nxt[prv[n]] = nxt[n];
    prv[nxt[n]] = prv[n];
  endfunction

  function automatic void push_head(int n, int k);
    int h;
    h = NBUF + k;
    nxt[n] = nxt[h];
    prv[n] = h;
    prv[nxt[h]] = n;
    nxt[h] = n;
  endfunction

  function automatic void cache_reset();
    for (int k = 0; k < NBKT; k++) begin
      nxt[NBUF+k] = NBUF + k;
      prv[NBUF+k] = NBUF + k;
    end
    for (int i = 0; i < NBUF; i++) begin
      c_dev[i] = '0; c_blk[i] = '0; c_val[i] = 0; c_refs[i] = '0;
      c_bkt[i] = i % NBKT;
      push_head(i, i % NBKT);
    end
  endfunction

  function automatic int find_hit(int k, logic [DEV_W-1:0] d, logic [BLK_W-1:0] b);
    int n;
    n = nxt[NBUF+k];
    while (n != NBUF + k) begin
      if (c_dev[n] == d && c_blk[n] == b) return n;
      n = nxt[n];
    end
    return -1;
  endfunction

  function automatic int find_unused(int k);
    int n;
    n = prv[NBUF+k];
    while (n != NBUF + k) begin
      if (c_refs[n] == 0) return n;
      n = prv[n];
    end
    return -1;
  endfunction

  function automatic void claim(int n, logic [DEV_W-1:0] d, logic [BLK_W-1:0] b);
    c_dev[n] = d; c_blk[n] = b; c_val[n] = 0; c_refs[n] = 1;
  endfunction

  function automatic rsp_t cache_predict(req_t r);
    rsp_t o;
    int home, k, n;
    bit hit;
    o = '0;
    o.granted_buffer = r.buffer_handle;
    o.status = ST_OK;
    if (r.req_type == REQ_GET) begin
      o.granted_buffer = '0;
      home = int'(r.block_number % NBKT);
      hit = 0;
      n = find_hit(home, r.device_id, r.block_number);
      if (n >= 0) begin
        hit = 1;
        if (c_refs[n] != 8'hFF) c_refs[n]++;
      end else begin
        n = find_unused(home);
        if (n >= 0) claim(n, r.device_id, r.block_number);
      end
      // spill into the other buckets in order
      for (int j = 1; j < NBKT && n < 0; j++) begin
        k = (home + j) % NBKT;
        n = find_hit(k, r.device_id, r.block_number);
        if (n >= 0) begin
          hit = 1;
          if (c_refs[n] != 8'hFF) c_refs[n]++;
        end else begin
          n = find_unused(k);
          if (n >= 0) claim(n, r.device_id, r.block_number);
        end
        if (n >= 0) begin
          c_bkt[n] = home;
          unlink(n);
          push_head(n, home);
        end
      end
      if (n >= 0) begin
        o.granted_buffer = n[HANDLE_W-1:0];
        o.was_cached = hit;
        o.needs_fill = !c_val[n];
        c_val[n] = 1;
      end else begin
        o.status = ST_NO_FREE;
      end
    end else if (r.buffer_handle < NBUF) begin
      n = int'(r.buffer_handle);
      if (r.req_type == REQ_PIN) begin
        if (c_refs[n] != 8'hFF) c_refs[n]++;
      end else if (c_refs[n] == 0) begin
        o.status = ST_UNDERFLOW;
      end else begin
        c_refs[n]--;
        if (r.req_type == REQ_RELEASE && c_refs[n] == 0) begin
          unlink(n);
          push_head(n, c_bkt[n]);
        end
      end
    end
    return o;
  endfunction

  function automatic req_t mk(logic [REQ_W-1:0] t, logic [DEV_W-1:0] d,
                              logic [BLK_W-1:0] b, logic [HANDLE_W-1:0] h);
    req_t r;
    r.req_type = t; r.device_id = d; r.block_number = b; r.buffer_handle = h;
    return r;
  endfunction

  // random request biased toward meaningful traffic
  function automatic req_t rand_req();
    req_t r;
    int p, i;
    r.device_id = DEV_W'($urandom);
    r.block_number = BLK_W'($urandom);
    r.buffer_handle = HANDLE_W'($urandom_range(0, NBUF - 1));
    r.req_type = REQ_GET;
    p = $urandom_range(0, 99);
    if (p < 40) begin
      if ($urandom_range(0, 2) != 0 && seen_blk.size() > 0) begin
        i = $urandom_range(0, seen_blk.size() - 1);
        r.device_id = seen_dev[i];
        r.block_number = seen_blk[i];
      end else if ($urandom_range(0, 3) == 0) begin
        r.device_id = DEV_W'($urandom_range(0, 3));
        r.block_number = BLK_W'($urandom_range(0, 60));
      end
      seen_dev.push_back(r.device_id);
      seen_blk.push_back(r.block_number);
      if (seen_blk.size() > 40) begin
        void'(seen_dev.pop_front());
        void'(seen_blk.pop_front());
      end
    end else if (p < 75) begin
      r.req_type = REQ_RELEASE;
    end else if (p < 83) begin
      r.req_type = REQ_PIN;
    end else if (p < 95) begin
      r.req_type = REQ_UNPIN;
    end else begin
      r.req_type = REQ_W'($urandom_range(1, 3));
      r.buffer_handle = HANDLE_W'($urandom_range(NBUF, 63));
    end
    return r;
  endfunction

  // request handshake seen at the rising edge
  always @(posedge clk) begin
    in_taken <= in_req.valid && in_req.ready;
  end

  // driver: request side, changes on falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      in_req.data  <= '0;
    end else if (!in_req.valid || in_taken) begin
      if (pending_reqs.size() > 0 && !drain_now &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_req.valid <= 1'b1;
        in_req.data  <= pending_reqs.pop_front();
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // receiver stall control, own hold-off counter
  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_cycles <= 800;
      out_rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n) begin
      if (in_req.valid && in_req.ready)
        expected_rsps.push_back(cache_predict(in_req.data));
      if (out_rsp.valid && out_rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response %p", out_rsp.data);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (out_rsp.data.granted_buffer !== e.granted_buffer) begin
            $error("granted_buffer exp %0d got %0d", e.granted_buffer,
                   out_rsp.data.granted_buffer);
            errors++;
          end
          if (out_rsp.data.needs_fill !== e.needs_fill) begin
            $error("needs_fill exp %0d got %0d", e.needs_fill, out_rsp.data.needs_fill);
            errors++;
          end
          if (out_rsp.data.was_cached !== e.was_cached) begin
            $error("was_cached exp %0d got %0d", e.was_cached, out_rsp.data.was_cached);
            errors++;
          end
          if (out_rsp.data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_rsp.data.status);
            errors++;
          end
        end
      end
    end
  end

  // wait until the driver has handed off every queued request and all answered
  task automatic settle();
    while (pending_reqs.size() > 0 || in_req.valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  task automatic queue_random(int cnt);
    for (int i = 0; i < cnt; i++) pending_reqs.push_back(rand_req());
  endtask

  // stimulus
  initial begin
    cache_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset-state hit, underflows, out-of-range handles, saturation
    pending_reqs.push_back(mk(REQ_GET, 8'h00, 32'h0, 6'd0));
    pending_reqs.push_back(mk(REQ_RELEASE, 8'h00, 32'h0, 6'd5));
    pending_reqs.push_back(mk(REQ_UNPIN, 8'h00, 32'h0, 6'd7));
    pending_reqs.push_back(mk(REQ_PIN, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    pending_reqs.push_back(mk(REQ_RELEASE, 8'hFF, 32'hFFFF_FFFF, 6'd30));
    pending_reqs.push_back(mk(REQ_GET, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    pending_reqs.push_back(mk(REQ_GET, 8'hFF, 32'hFFFF_FFFF, 6'd0));
    pending_reqs.push_back(mk(REQ_RELEASE, 8'h0, 32'h0, 6'd29));
    pending_reqs.push_back(mk(REQ_UNPIN, 8'h0, 32'h0, 6'd0));
    pending_reqs.push_back(mk(REQ_RELEASE, 8'h0, 32'h0, 6'd0));
    // exhaust the pool with distinct blocks, then one more fails
    for (int i = 0; i < NBUF + 1; i++)
      pending_reqs.push_back(mk(REQ_GET, 8'h12, 32'h1000 + i, 6'd0));
    send_idle_pct = 0; recv_stall_pct = 0;
    settle();
    // pin one buffer past saturation, then release every buffer twice
    for (int i = 0; i < 256; i++)
      pending_reqs.push_back(mk(REQ_PIN, 8'h0, 32'h0, 6'd3));
    for (int i = 0; i < NBUF; i++)
      for (int j = 0; j < 2; j++)
        pending_reqs.push_back(mk(REQ_RELEASE, 8'h0, 32'h0, i[5:0]));
    settle();

    // random phases
    queue_random(NRAND / 4);
    settle();
    send_idle_pct = 68; recv_stall_pct = 0;
    queue_random(NRAND / 4);
    settle();
    send_idle_pct = 0; recv_stall_pct = 68;
    queue_random(NRAND / 4);
    settle();
    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0; recv_stall_pct = 0;
    @(negedge clk);
    hold_reqs++;
    queue_random(40);
    settle();
    // sender pause until everything is back
    drain_now = 1;
    settle();
    drain_now = 0;
    send_idle_pct = 20; recv_stall_pct = 20;
    queue_random(NRAND / 4);
    settle();

    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("hashed_block_buffer_cache verification clean");
    end else begin
      $display("hashed_block_buffer_cache verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200ms;
    $display("hashed_block_buffer_cache verification failed");
    $finish;
  end

endmodule
